FILE: design/svwm_pkg.sv
package svwm_pkg;

  // Supply status codes
  typedef enum logic [1:0] {
    ST_INITIAL = 2'd0,
    ST_NORMAL  = 2'd1,
    ST_UNDER   = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned DEB_W      = 7;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t REG_UNDER_ENTER = 3'd0;
  localparam cfg_idx_t REG_UNDER_EXIT  = 3'd1;
  localparam cfg_idx_t REG_OVER_ENTER  = 3'd2;
  localparam cfg_idx_t REG_OVER_EXIT   = 3'd3;
  localparam cfg_idx_t REG_DEBOUNCE    = 3'd4;

  typedef struct packed {
    logic [LIMIT_W-1:0] under_enter_mv;
    logic [LIMIT_W-1:0] under_exit_mv;
    logic [LIMIT_W-1:0] over_enter_mv;
    logic [LIMIT_W-1:0] over_exit_mv;
    logic [DEB_W-1:0]   debounce_count;
  } cfg_t;

  localparam logic [LIMIT_W-1:0] UNDER_ENTER_RESET = 16'd6600;
  localparam logic [LIMIT_W-1:0] UNDER_EXIT_RESET  = 16'd7100;
  localparam logic [LIMIT_W-1:0] OVER_ENTER_RESET  = 16'd29000;
  localparam logic [LIMIT_W-1:0] OVER_EXIT_RESET   = 16'd28500;
  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET    = 7'd100;

  // mV = sample * 20067 / 2047, done as sample * ceil(20067 * 2^27 / 2047) >> 27.
  // Exact for samples below 2^16: the rounding excess stays under 2^27.
  localparam logic [63:0]  SCALE_NUM       = 64'd20067;
  localparam logic [63:0]  SCALE_DEN       = 64'd2047;
  localparam int unsigned  SCALE_SHIFT     = 27;
  localparam int unsigned  MULT_W          = 31;
  localparam logic [63:0]  SCALE_MULT_WIDE =
    ((SCALE_NUM << SCALE_SHIFT) + SCALE_DEN - 64'd1) / SCALE_DEN;
  localparam logic [MULT_W-1:0] SCALE_MULT = SCALE_MULT_WIDE[MULT_W-1:0];

  // Scaled voltage needs four bits more than the sample (gain just below 10)
  localparam int unsigned MV_EXTRA_W = 4;

  localparam logic [VOLT_W-1:0] VOLT_MAX = 16'hFFFF;

endpackage

FILE: design/svwm_cfg_regs.sv
module svwm_cfg_regs import svwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_UNDER_ENTER: cfg_nxt.under_enter_mv = cfg_wdata[LIMIT_W-1:0];
        REG_UNDER_EXIT:  cfg_nxt.under_exit_mv  = cfg_wdata[LIMIT_W-1:0];
        REG_OVER_ENTER:  cfg_nxt.over_enter_mv  = cfg_wdata[LIMIT_W-1:0];
        REG_OVER_EXIT:   cfg_nxt.over_exit_mv   = cfg_wdata[LIMIT_W-1:0];
        REG_DEBOUNCE:    cfg_nxt.debounce_count = cfg_wdata[DEB_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.under_enter_mv <= UNDER_ENTER_RESET;
      cfg_r.under_exit_mv  <= UNDER_EXIT_RESET;
      cfg_r.over_enter_mv  <= OVER_ENTER_RESET;
      cfg_r.over_exit_mv   <= OVER_EXIT_RESET;
      cfg_r.debounce_count <= DEBOUNCE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/svwm_scaler.sv
module svwm_scaler import svwm_pkg::*; #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [ADC_BITS-1:0]          sample,
  output logic [ADC_BITS+MV_EXTRA_W-1:0] mv
);

  localparam int unsigned MV_W   = ADC_BITS + MV_EXTRA_W;
  localparam int unsigned PROD_W = ADC_BITS + MULT_W;

  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   mv_nxt;
  logic [MV_W-1:0]   mv_r;

  // Constant reciprocal multiply, keep the integer part
  assign prod   = PROD_W'(sample) * PROD_W'(SCALE_MULT);
  assign mv_nxt = prod[SCALE_SHIFT +: MV_W];

  always_ff @(posedge clk) begin
    if (load) begin
      mv_r <= mv_nxt;
    end
  end

  assign mv = mv_r;

endmodule

FILE: design/svwm_classifier.sv
module svwm_classifier import svwm_pkg::*; #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [ADC_BITS+MV_EXTRA_W-1:0] mv,
  input  cfg_t                           cfg,
  output status_t                        status,
  output logic [VOLT_W-1:0]              voltage
);

  localparam int unsigned MV_W  = ADC_BITS + MV_EXTRA_W;
  localparam int unsigned CMP_W = (MV_W > LIMIT_W) ? MV_W : LIMIT_W;

  status_t            status_r;
  status_t            status_nxt;
  status_t            cls;
  logic [DEB_W-1:0]   left_r;
  logic [DEB_W-1:0]   left_nxt;
  logic [VOLT_W-1:0]  voltage_r;
  logic [VOLT_W-1:0]  voltage_nxt;
  logic [CMP_W-1:0]   mv_ext;
  logic [CMP_W-1:0]   low_lim;
  logic [CMP_W-1:0]   high_lim;
  logic               adopt;

  assign mv_ext = CMP_W'(mv);

  // Limits follow the current status for hysteresis
  always_comb begin
    low_lim  = CMP_W'(cfg.under_enter_mv);
    high_lim = CMP_W'(cfg.over_enter_mv);
    unique case (status_r)
      ST_UNDER:   low_lim  = CMP_W'(cfg.under_exit_mv);
      ST_OVER:    high_lim = CMP_W'(cfg.over_exit_mv);
      ST_INITIAL,
      ST_NORMAL:  ;
    endcase
  end

  // Under wins when the limits cross
  always_comb begin
    priority if (mv_ext < low_lim) begin
      cls = ST_UNDER;
    end else if (mv_ext > high_lim) begin
      cls = ST_OVER;
    end else begin
      cls = ST_NORMAL;
    end
  end

  always_comb begin
    status_nxt = status_r;
    left_nxt   = left_r;
    adopt      = 1'b0;
    priority if (status_r == ST_INITIAL) begin
      adopt = 1'b1;
    end else if (cls != status_r) begin
      if (left_r <= DEB_W'(1)) begin
        adopt = 1'b1;
      end else begin
        left_nxt = left_r - DEB_W'(1);
      end
    end else begin
      left_nxt = cfg.debounce_count;
    end
    if (adopt) begin
      status_nxt = cls;
      left_nxt   = cfg.debounce_count;
    end
  end

  assign voltage_nxt = (mv_ext > CMP_W'(VOLT_MAX)) ? VOLT_MAX : mv_ext[VOLT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_INITIAL;
      left_r   <= DEBOUNCE_RESET;
    end else if (load) begin
      status_r <= status_nxt;
      left_r   <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      voltage_r <= voltage_nxt;
    end
  end

  assign status  = status_r;
  assign voltage = voltage_r;

endmodule

FILE: design/supply_voltage_window_monitor.sv
// Supply voltage window monitor. Each request carries one raw ADC sample of the
// supply divider; the block scales it to millivolts (sample * 20067 / 2047,
// truncated, saturated at 65535 on the output), classifies it against under and
// over limits that move with the current status, and debounces status changes
// over debounce_count mismatching samples. Every request yields one result with
// the new status and the scaled voltage. A new sample is taken every clock
// cycle while the result port does not stall. An accepted sample moves from the
// input register to the voltage register, which loads the constant multiply,
// and then to the result register, which loads the status update.
// The status and debounce counter change as the result register loads, so
// consecutive samples see each other's effect without bubbles. Write the limit
// and debounce registers only while no request is in flight.
module supply_voltage_window_monitor import svwm_pkg::*; #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADC_BITS-1:0]   in_adc_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_supply_status,
  output logic [VOLT_W-1:0]     out_voltage_mv,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned MV_W = ADC_BITS + MV_EXTRA_W;

  cfg_t                cfg;
  logic [ADC_BITS-1:0] sample_r;
  logic [MV_W-1:0]     mv;
  status_t             status;

  logic s1_v_r;
  logic s1_v_nxt;
  logic s2_v_r;
  logic s2_v_nxt;
  logic out_v_r;
  logic out_v_nxt;
  logic out_free;
  logic s2_ready;
  logic s1_fire;
  logic s2_fire;
  logic in_fire;

  // Ready flows back through the stages: a stage may load when it is empty
  // or when it hands its own request on in the same cycle.
  assign out_free = !out_v_r || out_ready;
  assign s2_fire  = s2_v_r && out_free;
  assign s2_ready = !s2_v_r || out_free;
  assign s1_fire  = s1_v_r && s2_ready;
  assign in_ready = !s1_v_r || s2_ready;
  assign in_fire  = in_valid && in_ready;

  // Advance valid bits; a stage stays full when it loads or is stalled
  always_comb begin
    s1_v_nxt  = in_fire || (s1_v_r && !s2_ready);
    s2_v_nxt  = s1_fire || (s2_v_r && !out_free);
    out_v_nxt = s2_fire || (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold the accepted sample until the scaler takes it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_adc_sample;
    end
  end

  svwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  svwm_scaler #(
    .ADC_BITS (ADC_BITS)
  ) u_scaler (
    .clk    (clk),
    .load   (s1_fire),
    .sample (sample_r),
    .mv     (mv)
  );

  // The status register doubles as the result register: it only moves when
  // the result slot is free, so the shown status holds through a stall.
  svwm_classifier #(
    .ADC_BITS (ADC_BITS)
  ) u_classifier (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s2_fire),
    .mv      (mv),
    .cfg     (cfg),
    .status  (status),
    .voltage (out_voltage_mv)
  );

  assign out_valid         = out_v_r;
  assign out_supply_status = status;

endmodule

FILE: design/svwm_checker.sv
module svwm_checker import svwm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_supply_status,
  input logic [VOLT_W-1:0]     out_voltage_mv
);

  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The first sample always adopts a class, so a result never shows initial status
  a_no_initial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_supply_status != ST_INITIAL))
    else $error("result shows initial status");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_supply_status) && $stable(out_voltage_mv))
    else $error("stalled result changed");

  // With the sink ready, a request reaches the result port
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("request did not reach the result port");

endmodule

bind supply_voltage_window_monitor svwm_checker u_svwm_checker (.*);
